// ===== rtl/core/crcfc_pkg.sv =====
`timescale 1ns / 1ps

package crcfc_pkg;

  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [15:0] CRC_TOP     = 16'h8000;
  localparam logic [15:0] LEN_SAT     = 16'hFFFF;
  localparam logic [15:0] CRC_START_IDX = 16'd6;

  localparam logic [7:0]  START_MARKER_RST = 8'd50;
  localparam logic [7:0]  END_MARKER_RST   = 8'd52;
  localparam logic [15:0] MIN_LEN_RST      = 16'd16;
  localparam logic [15:0] MAX_LEN_RST      = 16'd1500;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_BAD_START     = 3'd1,
    ST_BAD_LENGTH    = 3'd2,
    ST_SIZE_MISMATCH = 3'd3,
    ST_BAD_END       = 3'd4,
    ST_BAD_CRC       = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    REG_START_MARKER = 2'd0,
    REG_END_MARKER   = 2'd1,
    REG_MIN_LEN      = 2'd2,
    REG_MAX_LEN      = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [7:0]  start_marker;
    logic [7:0]  end_marker;
    logic [15:0] min_frame_len;
    logic [15:0] max_frame_len;
  } cfg_t;

  typedef struct packed {
    logic [15:0] crc_value;
    logic [15:0] frame_length;
    status_t     status;
  } result_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/crcfc_frame_state.sv =====
`timescale 1ns / 1ps

module crcfc_frame_state (
  input  logic               clk,
  input  logic               rst,
  input  crcfc_pkg::cfg_t    cfg,
  input  logic               fire,
  input  logic [7:0]         data_byte,
  input  logic               last_byte,
  output crcfc_pkg::result_t result
);
  import crcfc_pkg::*;

  logic [15:0] byte_count;
  logic [15:0] byte_count_next;
  logic        start_seen_ok;
  logic        start_seen_ok_next;
  logic [15:0] size_field;
  logic [15:0] size_field_next;
  logic [7:0]  trailer_delay [3];
  logic [15:0] crc_accum;
  logic [15:0] crc_accum_next;
  logic [15:0] expected;
  logic [16:0] size_plus_two;

  always_comb begin
    start_seen_ok_next = start_seen_ok;
    size_field_next    = size_field;
    if (byte_count == 16'd0) begin
      start_seen_ok_next = (data_byte == cfg.start_marker);
    end else if (byte_count == 16'd1) begin
      size_field_next = {data_byte, size_field[7:0]};
    end else if (byte_count == 16'd2) begin
      size_field_next = {size_field[15:8], data_byte};
    end
    crc_accum_next  = (byte_count >= CRC_START_IDX) ?
                      crc_feed(crc_accum, trailer_delay[2]) : crc_accum;
    byte_count_next = (byte_count == LEN_SAT) ? byte_count : byte_count + 16'd1;
    expected        = {trailer_delay[1], trailer_delay[0]};
    size_plus_two   = {1'b0, size_field_next} + 17'd2;
  end

  always_comb begin
    result.frame_length = byte_count_next;
    result.crc_value    = crc_accum_next;
    if (!start_seen_ok_next) begin
      result.status = ST_BAD_START;
    end else if (byte_count_next < cfg.min_frame_len || byte_count_next > cfg.max_frame_len ||
                 byte_count_next == LEN_SAT) begin
      result.status = ST_BAD_LENGTH;
    end else if (size_plus_two != {1'b0, byte_count_next}) begin
      result.status = ST_SIZE_MISMATCH;
    end else if (data_byte != cfg.end_marker) begin
      result.status = ST_BAD_END;
    end else if (expected != crc_accum_next) begin
      result.status = ST_BAD_CRC;
    end else begin
      result.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && last_byte)) begin
      byte_count       <= '0;
      start_seen_ok    <= 1'b0;
      size_field       <= '0;
      trailer_delay[0] <= '0;
      trailer_delay[1] <= '0;
      trailer_delay[2] <= '0;
      crc_accum        <= '0;
    end else if (fire) begin
      byte_count       <= byte_count_next;
      start_seen_ok    <= start_seen_ok_next;
      size_field       <= size_field_next;
      trailer_delay[0] <= data_byte;
      trailer_delay[1] <= trailer_delay[0];
      trailer_delay[2] <= trailer_delay[1];
      crc_accum        <= crc_accum_next;
    end
  end

endmodule

// ===== rtl/core/crc_frame_checker.sv =====
`timescale 1ns / 1ps

// Frame checker for a byte stream: one byte per transaction, tlast on the final
// byte of a frame. Each byte is registered, then checked against the running frame
// state (start byte, length limits, size field, end byte, CRC-16/XMODEM over the
// payload) and, on the final byte, one status transaction is registered at the
// output. Throughput is one byte per clock; the status of a frame is computed from
// its final byte in the input register and held in the output register, which
// decouples the sides, so input keeps flowing while a status waits, and input stalls
// only when a final byte meets a still-occupied output. Configuration writes take
// effect on the next clock and are meant to be made between frames.
module crc_frame_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_index,
  input  logic [crcfc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [7:0]                         s_tdata,   // [7:0] data_byte
  input  logic                               s_tlast,   // last_byte
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [39:0]                        m_tdata    // [2:0] status, [18:3] frame_length,
                                                        // [34:19] crc_value, [39:35] zero
);
  import crcfc_pkg::*;

  cfg_t        cfg;
  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_last;
  logic        out_free;
  logic        fire;
  result_t     result;
  result_t     out_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_marker  <= START_MARKER_RST;
      cfg.end_marker    <= END_MARKER_RST;
      cfg.min_frame_len <= MIN_LEN_RST;
      cfg.max_frame_len <= MAX_LEN_RST;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_START_MARKER: cfg.start_marker  <= cfg_data[7:0];
        REG_END_MARKER:   cfg.end_marker    <= cfg_data[7:0];
        REG_MIN_LEN:      cfg.min_frame_len <= cfg_data[15:0];
        REG_MAX_LEN:      cfg.max_frame_len <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign out_free = !m_tvalid || m_tready;
  assign fire     = in_valid && (!in_last || out_free);
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  crcfc_frame_state u_state (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .fire      (fire),
    .data_byte (in_byte),
    .last_byte (in_last),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire && in_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_last) begin
      out_result <= result;
    end
  end

  assign m_tdata = {5'b00000, out_result.crc_value, out_result.frame_length,
                    out_result.status};

endmodule

// ===== rtl/core/crcfc_checker.sv =====
`timescale 1ns / 1ps

module crcfc_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);
  import crcfc_pkg::*;

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("status transaction dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("status payload changed while stalled");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2:0] == ST_OK || m_tdata[2:0] == ST_BAD_START ||
                  m_tdata[2:0] == ST_BAD_LENGTH || m_tdata[2:0] == ST_SIZE_MISMATCH ||
                  m_tdata[2:0] == ST_BAD_END || m_tdata[2:0] == ST_BAD_CRC))
    else $error("status code out of range");

  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[18:3] != 16'd0 && m_tdata[39:35] == 5'd0))
    else $error("empty frame length or nonzero padding");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind crc_frame_checker crcfc_checker u_crcfc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== verif/tb_crc_frame_checker.sv =====
`timescale 1ns / 1ps

module tb_crc_frame_checker;
  import crcfc_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 6;
  localparam int RANDOM_ITEMS = 1550;

  typedef enum int {
    FK_GOOD,
    FK_BAD_START,
    FK_BAD_SIZE,
    FK_BAD_END,
    FK_BAD_CRC,
    FK_NOISE
  } frame_kind_t;

  class frame_scoreboard;
    logic [7:0]  start_marker;
    logic [7:0]  end_marker;
    logic [15:0] min_len;
    logic [15:0] max_len;
    logic [15:0] byte_count;
    logic        start_ok;
    logic [15:0] size_field;
    logic [7:0]  trail [3];
    logic [15:0] crc_acc;
    result_t     expected_q [$];
    int          errors;
    int          bytes_seen;
    int          statuses_seen;

    function new();
      start_marker  = START_MARKER_RST;
      end_marker    = END_MARKER_RST;
      min_len       = MIN_LEN_RST;
      max_len       = MAX_LEN_RST;
      errors        = 0;
      bytes_seen    = 0;
      statuses_seen = 0;
      clear_frame();
    endfunction

    static function logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      repeat (8) c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      return c;
    endfunction

    function void clear_frame();
      byte_count = '0;
      start_ok   = 1'b0;
      size_field = '0;
      trail[0]   = '0;
      trail[1]   = '0;
      trail[2]   = '0;
      crc_acc    = '0;
    endfunction

    function void set_reg(reg_index_t idx, logic [15:0] v);
      case (idx)
        REG_START_MARKER: start_marker = v[7:0];
        REG_END_MARKER:   end_marker   = v[7:0];
        REG_MIN_LEN:      min_len      = v;
        REG_MAX_LEN:      max_len      = v;
        default: ;
      endcase
    endfunction

    function void take_byte(logic [7:0] b, logic last);
      logic [15:0] want;
      result_t     r;
      bytes_seen++;
      if (byte_count == 16'd0) start_ok = (b == start_marker);
      else if (byte_count == 16'd1) size_field[15:8] = b;
      else if (byte_count == 16'd2) size_field[7:0] = b;
      if (byte_count >= CRC_START_IDX) crc_acc = crc_step(crc_acc, trail[2]);
      want = {trail[1], trail[0]};
      trail[2] = trail[1];
      trail[1] = trail[0];
      trail[0] = b;
      if (byte_count != LEN_SAT) byte_count++;
      if (!last) return;
      if (!start_ok) begin
        r.status = ST_BAD_START;
      end else if (byte_count < min_len || byte_count > max_len || byte_count == LEN_SAT) begin
        r.status = ST_BAD_LENGTH;
      end else if (int'(size_field) + 2 != int'(byte_count)) begin
        r.status = ST_SIZE_MISMATCH;
      end else if (b != end_marker) begin
        r.status = ST_BAD_END;
      end else if (want != crc_acc) begin
        r.status = ST_BAD_CRC;
      end else begin
        r.status = ST_OK;
      end
      r.frame_length = byte_count;
      r.crc_value    = crc_acc;
      expected_q.push_back(r);
      clear_frame();
    endfunction

    function void check_status(logic [39:0] tdata);
      result_t got;
      result_t want;
      statuses_seen++;
      got = result_t'(tdata[34:0]);
      if (expected_q.size() == 0) begin
        $error("status transaction with none expected: tdata %h", tdata);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.frame_length !== want.frame_length) begin
        $error("frame_length: expected %0d, actual %0d", want.frame_length, got.frame_length);
        errors++;
      end
      if (got.crc_value !== want.crc_value) begin
        $error("crc_value: expected %h, actual %h", want.crc_value, got.crc_value);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;

  frame_scoreboard sb = new();
  bit tx_quiet  = 1'b0;
  bit rx_quiet  = 1'b0;
  bit hold_req  = 1'b0;
  int n_frames   = 0;
  int n_settings = 0;

  crc_frame_checker dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.take_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) sb.check_status(m_tdata);
    end
  end

  initial begin
    int stall;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        stall    = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        stall = rx_quiet ? 0 : $urandom_range(0, 4);
      end
      if (stall > 0) begin
        m_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready = 1'b1;
      do @(posedge clk); while (!m_tvalid && !hold_req);
      @(negedge clk);
    end
  end

  initial begin
    #50_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = b;
    s_tlast  = last;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic send_frame(int len, frame_kind_t kind);
    logic [7:0]  fr [$];
    logic [15:0] crc;
    logic [15:0] sz;
    logic [7:0]  flip;
    for (int i = 0; i < len; i++) fr.push_back(8'($urandom));
    flip = 8'($urandom_range(1, 255));
    if (kind != FK_NOISE) begin
      crc = '0;
      for (int i = 3; i <= len - 4; i++) crc = frame_scoreboard::crc_step(crc, fr[i]);
      sz = 16'(len - 2);
      fr[0] = sb.start_marker;
      if (len > 1) fr[1] = sz[15:8];
      if (len > 2) fr[2] = sz[7:0];
      if (len > 2) fr[len - 3] = crc[15:8];
      if (len > 1) fr[len - 2] = crc[7:0];
      fr[len - 1] = sb.end_marker;
      case (kind)
        FK_BAD_START: fr[0] ^= flip;
        FK_BAD_SIZE:  fr[$urandom_range(1, 2)] ^= flip;
        FK_BAD_END:   fr[len - 1] ^= flip;
        FK_BAD_CRC:   fr[$urandom_range(3, len - 2)] ^= flip;
        default: ;
      endcase
    end
    for (int i = 0; i < len; i++) send_byte(fr[i], i == len - 1);
    n_frames++;
  endtask

  task automatic wait_idle();
    s_tvalid = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic configure(logic [7:0] sm, logic [7:0] em, logic [15:0] mn, logic [15:0] mx);
    logic [15:0] vals [4];
    vals[0] = {8'h00, sm};
    vals[1] = {8'h00, em};
    vals[2] = mn;
    vals[3] = mx;
    wait_idle();
    for (int i = 0; i < 4; i++) begin
      cfg_we    = 1'b1;
      cfg_index = reg_index_t'(i);
      cfg_data  = vals[i];
      @(negedge clk);
      sb.set_reg(reg_index_t'(i), vals[i]);
    end
    cfg_we = 1'b0;
    n_settings++;
  endtask

  function automatic logic [7:0] pick_marker();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom);
  endfunction

  initial begin
    int          target;
    int          len;
    int          k;
    int          lo;
    int          hi;
    logic [15:0] mn;
    logic [15:0] mx;
    frame_kind_t kind;

    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tlast   = 1'b0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // reset limits: shortest legal frame, then one byte short
    send_frame(16, FK_GOOD);
    send_frame(15, FK_GOOD);

    configure(8'h00, 8'hFF, 16'd6, 16'd40);
    send_frame(6, FK_GOOD);
    send_frame(1, FK_NOISE);
    send_frame(5, FK_GOOD);
    send_frame(6, FK_BAD_START);
    send_frame(6, FK_BAD_SIZE);
    send_frame(6, FK_BAD_END);
    send_frame(7, FK_BAD_CRC);

    configure(8'hFF, 8'h00, 16'd6, 16'd6);
    send_frame(6, FK_GOOD);
    send_frame(7, FK_GOOD);

    // crossed limits
    configure(8'hA5, 8'h5A, 16'hFFFF, 16'd6);
    send_frame(6, FK_GOOD);
    send_frame(8, FK_GOOD);

    // longest legal frame, then the saturating ones
    configure(pick_marker(), pick_marker(), 16'd6, 16'hFFFF);
    tx_quiet = 1'b1;
    send_frame(65534, FK_GOOD);
    send_frame(65535, FK_GOOD);
    send_frame(65540, FK_NOISE);

    // hold the output off while short frames keep arriving
    configure(pick_marker(), pick_marker(), 16'd6, 16'd8);
    hold_req = 1'b1;
    for (int f = 0; f < 40; f++) send_frame($urandom_range(6, 8), FK_GOOD);
    tx_quiet = 1'b0;

    target = sb.bytes_seen + RANDOM_ITEMS;
    while (sb.bytes_seen < target) begin
      if ($urandom_range(0, 7) == 0) begin
        mn = 16'($urandom_range(12, 24));
        mx = 16'($urandom_range(6, int'(mn) - 1));
      end else begin
        mn = 16'($urandom_range(6, 24));
        mx = 16'($urandom_range(int'(mn), 64));
      end
      configure(pick_marker(), pick_marker(), mn, mx);
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      for (int f = $urandom_range(6, 16); f > 0; f--) begin
        k = $urandom_range(0, 99);
        kind = k < 55 ? FK_GOOD : k < 63 ? FK_BAD_START : k < 71 ? FK_BAD_SIZE :
               k < 79 ? FK_BAD_END : k < 90 ? FK_BAD_CRC : FK_NOISE;
        lo = int'(sb.min_len) - 1;
        hi = int'(sb.max_len) + 1;
        if ($urandom_range(0, 9) == 0) len = $urandom_range(1, 8);
        else if (lo > hi) len = $urandom_range(6, 40);
        else len = $urandom_range(lo, hi);
        if (len < 5 && kind inside {FK_BAD_START, FK_BAD_SIZE, FK_BAD_END, FK_BAD_CRC}) len = 5;
        send_frame(len, kind);
      end
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;

    wait_idle();
    $display("tb: %0d bytes in %0d frames, %0d statuses checked over %0d register settings",
             sb.bytes_seen, n_frames, sb.statuses_seen, n_settings);
    $display("tb: covered every status, saturated and crossed limits, and a long output stall");
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
